### rtl/assert_macros.svh
// Assertion macros used by the checker file of the hit summarizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define EHS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("event hit summarizer check failed");

// Consequent checked in the cycle after the antecedent.
`define EHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("event hit summarizer check failed");

`endif

### rtl/ehs_pkg.sv
// Types, widths and constants shared by the hit summarizer modules.
`default_nettype none

package ehs_pkg;

  localparam int TIME_W     = 16;
  localparam int TYPE_W     = 2;
  localparam int CHG_W      = 16;
  localparam int CNT_W      = 12;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 48;
  localparam int BAL_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W = TIME_W + CHG_W;
  localparam int OUT_TDATA_W = 4 * CNT_W + 2 * SUM_W + CHG_W + BAL_W;

  // back-end arithmetic widths
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int A_W    = SQ_W + CNT_W;      // S2 * N
  localparam int B_W    = 2 * SUM_W;         // S1 * S1
  localparam int DEN_W  = B_W + CNT_W;       // S1^2 * N
  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(5);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(31);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(15);

  localparam logic [SUM_W-1:0] SQRT_BIT0 = SUM_W'(32'h4000_0000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PED_LO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PED_HI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROMPT_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROMPT_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_LO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_HI   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_TYPE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VETO_TYPE = 3'd7;

  localparam logic signed [TIME_W-1:0] PED_LO_RST    = -16'sd600;
  localparam logic signed [TIME_W-1:0] PED_HI_RST    = -16'sd200;
  localparam logic signed [TIME_W-1:0] PROMPT_LO_RST = -16'sd80;
  localparam logic signed [TIME_W-1:0] PROMPT_HI_RST = 16'sd320;
  localparam logic signed [TIME_W-1:0] WIDE_LO_RST   = -16'sd200;
  localparam logic signed [TIME_W-1:0] WIDE_HI_RST   = 16'sd1400;
  localparam logic [TYPE_W-1:0]        SIG_TYPE_RST  = 2'd1;
  localparam logic [TYPE_W-1:0]        VETO_TYPE_RST = 2'd2;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_LOAD,
    ST_MUL,
    ST_CHECK,
    ST_RANGE,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } ehs_state_e;

  // multiplier step: operand pair issued; product of the previous step retired
  typedef enum logic [2:0] {
    MS_SQ_SUM,
    MS_S2_LO,
    MS_S2_HI,
    MS_B_LO,
    MS_B_HI,
    MS_FLUSH
  } mul_step_e;

  typedef struct packed {
    logic      load;
    logic      mul_en;
    mul_step_e mul_sel;
    logic      check;
    logic      range;
    logic      div_en;
    logic      sqrt_en;
    logic      finish;
  } ehs_cmd_t;

  typedef struct packed {
    logic event_ready;
    logic out_busy;
    logic zero;
    logic sat;
  } ehs_sts_t;

endpackage

`default_nettype wire

### rtl/ehs_ctrl.sv
// Sequencer for the end-of-event back stage of the hit summarizer.
`default_nettype none

module ehs_ctrl import ehs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ehs_sts_t sts_i,
  output ehs_cmd_t cmd_o
);

  ehs_state_e        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      ST_ACCUM: begin
        if (sts_i.event_ready && !sts_i.out_busy) state_d = ST_LOAD;
      end
      ST_LOAD: state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == MUL_LAST) state_d = ST_CHECK;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_CHECK: state_d = ST_RANGE;
      ST_RANGE: begin
        if (sts_i.zero || sts_i.sat) state_d = ST_DONE;
        else state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == DIV_LAST) state_d = ST_SQRT;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_SQRT: begin
        if (cnt_q == SQRT_LAST) state_d = ST_DONE;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_DONE: state_d = ST_ACCUM;
      default: state_d = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = mul_step_e'(cnt_q[2:0]);
    unique case (state_q)
      ST_LOAD:  cmd_o.load    = 1'b1;
      ST_MUL:   cmd_o.mul_en  = 1'b1;
      ST_CHECK: cmd_o.check   = 1'b1;
      ST_RANGE: cmd_o.range   = 1'b1;
      ST_DIV:   cmd_o.div_en  = 1'b1;
      ST_SQRT:  cmd_o.sqrt_en = 1'b1;
      ST_DONE:  cmd_o.finish  = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/ehs_datapath.sv
// Hit accumulation pipeline, balance arithmetic and result register.
`default_nettype none

module ehs_datapath import ehs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [TIME_W-1:0] hit_time_i,
  input  logic [TYPE_W-1:0]        tube_type_i,
  input  logic [CHG_W-1:0]         charge_i,
  input  logic                     last_hit_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [OUT_TDATA_W-1:0]   out_data_o,
  input  ehs_cmd_t                 cmd_i,
  output ehs_sts_t                 sts_o
);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // configuration
  logic signed [TIME_W-1:0] ped_lo_q, ped_hi_q, prompt_lo_q, prompt_hi_q;
  logic signed [TIME_W-1:0] wide_lo_q, wide_hi_q;
  logic [TYPE_W-1:0]        sig_type_q, veto_type_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ped_lo_q    <= PED_LO_RST;
      ped_hi_q    <= PED_HI_RST;
      prompt_lo_q <= PROMPT_LO_RST;
      prompt_hi_q <= PROMPT_HI_RST;
      wide_lo_q   <= WIDE_LO_RST;
      wide_hi_q   <= WIDE_HI_RST;
      sig_type_q  <= SIG_TYPE_RST;
      veto_type_q <= VETO_TYPE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PED_LO:    ped_lo_q    <= cfg_wdata_i;
        REG_PED_HI:    ped_hi_q    <= cfg_wdata_i;
        REG_PROMPT_LO: prompt_lo_q <= cfg_wdata_i;
        REG_PROMPT_HI: prompt_hi_q <= cfg_wdata_i;
        REG_WIDE_LO:   wide_lo_q   <= cfg_wdata_i;
        REG_WIDE_HI:   wide_hi_q   <= cfg_wdata_i;
        REG_SIG_TYPE:  sig_type_q  <= cfg_wdata_i[TYPE_W-1:0];
        REG_VETO_TYPE: veto_type_q <= cfg_wdata_i[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: window decode and charge square
  logic                   accept;
  logic                   pend_q;
  logic                   s1_valid_q;
  logic                   s1_sig_q, s1_veto_q, s1_ped_q, s1_prompt_q, s1_wide_q;
  logic [CHG_W-1:0]       s1_charge_q;
  logic [2*CHG_W-1:0]     s1_sq_q;
  logic [2*CHG_W-1:0]     charge_sq;

  assign in_ready_o = !pend_q;
  assign accept     = in_valid_i && in_ready_o;
  assign charge_sq  = charge_i * charge_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (cmd_i.load) pend_q <= 1'b0;
      else if (accept && last_hit_i) pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sig_q    <= tube_type_i == sig_type_q;
      s1_veto_q   <= tube_type_i == veto_type_q;
      s1_ped_q    <= (hit_time_i > ped_lo_q) && (hit_time_i < ped_hi_q);
      s1_prompt_q <= (hit_time_i > prompt_lo_q) && (hit_time_i < prompt_hi_q);
      s1_wide_q   <= (hit_time_i > wide_lo_q) && (hit_time_i < wide_hi_q);
      s1_charge_q <= charge_i;
      s1_sq_q     <= charge_sq;
    end
  end

  // stage 2: per-event accumulators
  logic [CNT_W-1:0] all_cnt_q, ped_cnt_q, prompt_cnt_q, wide_cnt_q, veto_cnt_q;
  logic [SUM_W-1:0] sig_sum_q, veto_sum_q;
  logic [SQ_W-1:0]  sq_sum_q;
  logic [CHG_W-1:0] peak_q;
  logic [SUM_W:0]   sig_sum_ext, veto_sum_ext;
  logic [SQ_W:0]    sq_sum_ext;

  assign sig_sum_ext  = {1'b0, sig_sum_q} + (SUM_W + 1)'(s1_charge_q);
  assign veto_sum_ext = {1'b0, veto_sum_q} + (SUM_W + 1)'(s1_charge_q);
  assign sq_sum_ext   = {1'b0, sq_sum_q} + (SQ_W + 1)'(s1_sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_cnt_q    <= '0;
      ped_cnt_q    <= '0;
      prompt_cnt_q <= '0;
      wide_cnt_q   <= '0;
      veto_cnt_q   <= '0;
      sig_sum_q    <= '0;
      veto_sum_q   <= '0;
      sq_sum_q     <= '0;
      peak_q       <= '0;
    end else if (cmd_i.load) begin
      all_cnt_q    <= '0;
      ped_cnt_q    <= '0;
      prompt_cnt_q <= '0;
      wide_cnt_q   <= '0;
      veto_cnt_q   <= '0;
      sig_sum_q    <= '0;
      veto_sum_q   <= '0;
      sq_sum_q     <= '0;
      peak_q       <= '0;
    end else if (s1_valid_q) begin
      all_cnt_q <= sat_inc(all_cnt_q);
      if (s1_sig_q) begin
        if (s1_ped_q)    ped_cnt_q    <= sat_inc(ped_cnt_q);
        if (s1_prompt_q) prompt_cnt_q <= sat_inc(prompt_cnt_q);
        if (s1_wide_q)   wide_cnt_q   <= sat_inc(wide_cnt_q);
        sig_sum_q <= sig_sum_ext[SUM_W] ? '1 : sig_sum_ext[SUM_W-1:0];
        sq_sum_q  <= sq_sum_ext[SQ_W] ? '1 : sq_sum_ext[SQ_W-1:0];
        if (s1_charge_q > peak_q) peak_q <= s1_charge_q;
      end
      if (s1_veto_q) begin
        if (s1_wide_q) veto_cnt_q <= sat_inc(veto_cnt_q);
        veto_sum_q <= veto_sum_ext[SUM_W] ? '1 : veto_sum_ext[SUM_W-1:0];
      end
    end
  end

  // result register
  logic [CNT_W-1:0] out_ped_q, out_prompt_q, out_wide_q, out_veto_q;
  logic [SUM_W-1:0] out_ssum_q, out_vsum_q;
  logic [CHG_W-1:0] out_peak_q;
  logic [BAL_W-1:0] bal_q;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.finish) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {bal_q, out_peak_q, out_vsum_q, out_ssum_q,
                        out_veto_q, out_wide_q, out_prompt_q, out_ped_q};

  // balance arithmetic: x = (S2*N - S1^2) / (S1^2 * N), then floor sqrt
  logic [SUM_W-1:0]  s1c_q;
  logic [SQ_W-1:0]   s2c_q;
  logic [CNT_W-1:0]  nc_q;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod, prod_q;
  logic [A_W-1:0]    a_q;
  logic [B_W-1:0]    b_q;
  logic [DEN_W-1:0]  den_q, num_q;
  logic [B_W-1:0]    diff;
  logic              zero_c, sat_c, zero_q, sat_q;
  logic [DEN_W:0]    num2, num_rem;
  logic              div_ge;
  logic [SUM_W-1:0]  quot_q, root_q, bit_q, trial;
  logic              sq_take;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MS_SQ_SUM: begin
        mul_a = s1c_q;
        mul_b = s1c_q;
      end
      MS_S2_LO: begin
        mul_a = s2c_q[MUL_W-1:0];
        mul_b = MUL_W'(nc_q);
      end
      MS_S2_HI: begin
        mul_a = MUL_W'(s2c_q[SQ_W-1:MUL_W]);
        mul_b = MUL_W'(nc_q);
      end
      MS_B_LO: begin
        mul_a = b_q[MUL_W-1:0];
        mul_b = MUL_W'(nc_q);
      end
      MS_B_HI: begin
        mul_a = b_q[B_W-1:MUL_W];
        mul_b = MUL_W'(nc_q);
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign zero_c  = (s1c_q == '0) || (nc_q == '0) || (b_q >= B_W'(a_q));
  assign diff    = B_W'(a_q) - b_q;
  assign sat_c   = num_q >= den_q;
  assign num2    = {num_q, 1'b0};
  assign div_ge  = num2 >= {1'b0, den_q};
  assign num_rem = num2 - {1'b0, den_q};
  assign trial   = root_q + bit_q;
  assign sq_take = quot_q >= trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_ped_q    <= ped_cnt_q;
      out_prompt_q <= prompt_cnt_q;
      out_wide_q   <= wide_cnt_q;
      out_veto_q   <= veto_cnt_q;
      out_ssum_q   <= sig_sum_q;
      out_vsum_q   <= veto_sum_q;
      out_peak_q   <= peak_q;
      s1c_q        <= sig_sum_q;
      s2c_q        <= sq_sum_q;
      nc_q         <= all_cnt_q;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod;
      // retire the product issued in the previous step
      case (cmd_i.mul_sel)
        MS_S2_LO: b_q   <= prod_q;
        MS_S2_HI: a_q   <= prod_q[A_W-1:0];
        MS_B_LO:  a_q   <= a_q + {prod_q[A_W-MUL_W-1:0], {MUL_W{1'b0}}};
        MS_B_HI:  den_q <= DEN_W'(prod_q);
        MS_FLUSH: den_q <= den_q + {prod_q[DEN_W-MUL_W-1:0], {MUL_W{1'b0}}};
        default: ;
      endcase
    end
    if (cmd_i.check) begin
      zero_q <= zero_c;
      sat_q  <= 1'b0;
      num_q  <= DEN_W'(diff);
    end
    if (cmd_i.range) begin
      sat_q  <= sat_c;
      quot_q <= '0;
      root_q <= '0;
      bit_q  <= SQRT_BIT0;
    end
    if (cmd_i.div_en) begin
      num_q  <= div_ge ? num_rem[DEN_W-1:0] : num2[DEN_W-1:0];
      quot_q <= {quot_q[SUM_W-2:0], div_ge};
    end
    if (cmd_i.sqrt_en) begin
      if (sq_take) begin
        quot_q <= quot_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.finish) begin
      if (zero_q) bal_q <= '0;
      else if (sat_q) bal_q <= '1;
      else bal_q <= root_q[BAL_W-1:0];
    end
  end

  assign sts_o.event_ready = pend_q && !s1_valid_q;
  assign sts_o.out_busy    = out_valid_q;
  assign sts_o.zero        = zero_q;
  assign sts_o.sat         = sat_c;

endmodule

`default_nettype wire

### rtl/event_hit_summarizer_unit.sv
// Event hit summarizer: top level joining the sequencer and the datapath.
//
// Input stream: one photomultiplier hit per beat; tdata carries time and
// charge, tuser the tube type, tlast the last hit of the event. Hits are
// taken one per cycle for as long as the event lasts.
// Output stream: one summary beat per event (counts, charge sums, peak
// charge and charge balance).
// After a beat with tlast is taken, s_axis_tready stays low until the event
// is handed to the back stage: the hit pipeline drains, then the event is loaded
// once the back stage is idle and the output register has been taken.
// The back stage then runs on its own while the next event's hits flow in:
// products on the shared 32x32 multiplier, range checks, the restoring
// divider and the bit-serial square root; the divider and square root are
// skipped when the balance is forced to zero or to full scale.
// A stalled receiver holds the summary in the output register; the next
// event's hits are still taken and only its hand-off waits.
// Reset clears the accumulators and handshake flags and restores the
// configuration defaults; s_axis_tready is high right after reset.
`default_nettype none

module event_hit_summarizer_unit import ehs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // hit_time [15:0], charge [31:16]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tube_type [1:0]
  input  logic [TYPE_W-1:0]      s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // pedestal_count [11:0], prompt_count [23:12], wide_count [35:24],
  // veto_count [47:36], signal_charge_total [79:48],
  // veto_charge_total [111:80], peak_charge [127:112], charge_balance [143:128]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  ehs_cmd_t cmd;
  ehs_sts_t sts;

  ehs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ehs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .hit_time_i  (s_axis_tdata[TIME_W-1:0]),
    .tube_type_i (s_axis_tuser),
    .charge_i    (s_axis_tdata[IN_TDATA_W-1:TIME_W]),
    .last_hit_i  (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

### rtl/ehs_checker.sv
// Port-level assertions for the event hit summarizer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ehs_checker import ehs_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_we_i,
  input logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [TYPE_W-1:0]      s_axis_tuser,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // an event end closes the input until the back stage has taken the event
  `EHS_ASSERT_NEXT(a_last_closes_input, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

  `EHS_ASSERT_NEXT(a_out_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  `EHS_ASSERT_NEXT(a_out_data_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // no signal charge means no balance
  `EHS_ASSERT_SAME(a_zero_charge_balance, m_axis_tvalid && (m_axis_tdata[79:48] == 32'd0), m_axis_tdata[143:128] == 16'd0)

  // the peak hit is part of the signal sum
  `EHS_ASSERT_SAME(a_peak_within_sum, m_axis_tvalid, m_axis_tdata[79:48] >= m_axis_tdata[127:112])

endmodule

bind event_hit_summarizer_unit ehs_checker u_ehs_checker (.*);

`default_nettype wire
